@@ src/tqc_pkg.sv @@
// Shared types, codes and field widths for the timer queue with cancel.
// No dependencies; imported by the top level, the slot store and the testbench.
package tqc_pkg;

    localparam int TIME_W  = 48;
    localparam int ID_W    = 32;
    localparam int DELAY_W = 32;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        CMD_ADD        = 2'd0,
        CMD_CANCEL     = 2'd1,
        CMD_CANCEL_ALL = 2'd2,
        CMD_TICK       = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        KIND_ADD_ACK        = 2'd0,
        KIND_CANCEL_ACK     = 2'd1,
        KIND_CANCEL_ALL_ACK = 2'd2,
        KIND_EXPIRY         = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_CANCEL_SCAN,
        S_CALL_SCAN,
        S_TICK_SCAN,
        S_TICK_NEXT,
        S_RESP
    } t_state;

    typedef struct packed {
        t_cmd_code          command;
        logic [DELAY_W-1:0] delay;
        logic [ID_W-1:0]    target_id;
    } t_cmd;

    typedef struct packed {
        t_kind              kind;
        logic [ID_W-1:0]    timer_id;
        logic               was_cancelled;
        logic               status;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_res;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [ID_W-1:0]   id;
    } t_slot;

endpackage

@@ src/tqc_stream_if.sv @@
// Valid/ready channel carrying one payload beat of type T.
// Used for the command and result channels; no package dependency.
interface tqc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ src/timer_queue_with_cancel.sv @@
// Timer queue with cancel: top level, command sequencer and slot scan.
// Depends on tqc_pkg, tqc_stream_if and tqc_slot_mem.
//
//  channel  dir  beat     payload
//  i_cmd    in   command  command, delay, target_id
//  o_res    out  result   kind, timer_id, was_cancelled, status, count, last
//
// N = TIMER_SLOTS. Every command scans the slots one per cycle, after it is accepted in idle.
// Add stops at the first free slot and cancel at the first match; cancel all scans every slot.
// Tick: one scan pass per expired timer plus one, then the last expiry
// beat is handed off when any timer fired.
// One result register on the output; the sequencer holds its next result while it is full.
// Synchronous active-low reset clears all valid and cancel flags; no command beat in reset.
module timer_queue_with_cancel
    import tqc_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tqc_stream_if.sink   i_cmd,
    tqc_stream_if.source o_res
);

    localparam int SLOT_W = $clog2(TIMER_SLOTS);
    localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
    localparam logic [CNT_W-1:0] N_CNT = CNT_W'(TIMER_SLOTS);

    t_state                 r_state, n_state;
    t_cmd                   r_cmd;
    logic [CNT_W-1:0]       r_idx;
    logic [CNT_W-1:0]       r_count;
    logic                   r_rd_vld;
    logic [SLOT_W-1:0]      r_rd_slot;
    logic [TIMER_SLOTS-1:0] r_valid;
    logic [TIMER_SLOTS-1:0] r_canc;
    logic [TIME_W-1:0]      r_time;
    logic [ID_W-1:0]        r_next_id;
    logic                   r_best_found;
    logic [SLOT_W-1:0]      r_best_slot;
    logic                   r_best_canc;
    logic [TIME_W-1:0]      r_best_dl;
    logic [ID_W-1:0]        r_best_id;
    t_res                   r_pend;
    logic                   r_pend_vld;
    t_res                   r_out;
    logic                   r_out_vld;

    t_slot                  w_rd;
    t_slot                  w_wdata;
    logic [SLOT_W-1:0]      w_idx;
    logic                   w_scan_more;
    logic                   w_pass_end;
    logic                   w_out_free;
    logic                   w_add_free;
    logic                   w_hit;
    logic                   w_cand_exp;
    logic                   w_better;
    logic [ID_W-1:0]        w_id_inc;
    logic [TIME_W:0]        w_dl_sum;
    logic                   w_mem_rd;
    logic                   w_mem_we;
    logic                   w_load_out;
    logic                   w_cmd_ready;

    function automatic t_res make_res(t_kind kind, logic [ID_W-1:0] id, logic canc,
                                      logic status, logic [COUNT_W-1:0] count,
                                      logic last);
        t_res r;
        r.kind          = kind;
        r.timer_id      = id;
        r.was_cancelled = canc;
        r.status        = status;
        r.count         = count;
        r.last          = last;
        return r;
    endfunction

    // candidate fires before current best
    function automatic logic fires_before(logic ca, logic [TIME_W-1:0] da,
                                          logic [ID_W-1:0] ia, logic cb,
                                          logic [TIME_W-1:0] db, logic [ID_W-1:0] ib);
        logic res;
        if (ca != cb) begin
            res = ca;
        end else if (!ca && da != db) begin
            res = da < db;
        end else begin
            res = ia < ib;
        end
        return res;
    endfunction

    tqc_slot_mem #(
        .DEPTH (TIMER_SLOTS)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_idx),
        .i_wdata (w_wdata),
        .i_re    (w_mem_rd),
        .i_raddr (w_idx),
        .o_rdata (w_rd)
    );

    assign w_idx       = r_idx[SLOT_W-1:0];
    assign w_scan_more = r_idx != N_CNT;
    assign w_pass_end  = !w_scan_more && !r_rd_vld;
    assign w_out_free  = !r_out_vld || o_res.ready;
    assign w_add_free  = w_scan_more && !r_valid[w_idx];
    assign w_hit       = r_rd_vld && r_valid[r_rd_slot] && !r_canc[r_rd_slot]
                         && (w_rd.id == r_cmd.target_id);
    assign w_cand_exp  = r_rd_vld && r_valid[r_rd_slot]
                         && (r_canc[r_rd_slot] || w_rd.deadline <= r_time);
    assign w_better    = !r_best_found
                         || fires_before(r_canc[r_rd_slot], w_rd.deadline, w_rd.id,
                                         r_best_canc, r_best_dl, r_best_id);
    assign w_id_inc    = (r_next_id + ID_W'(1) == '0) ? ID_W'(1) : r_next_id + ID_W'(1);
    assign w_dl_sum    = {1'b0, r_time} + (TIME_W + 1)'(r_cmd.delay);
    assign w_wdata.deadline = w_dl_sum[TIME_W] ? {TIME_W{1'b1}} : w_dl_sum[TIME_W-1:0];
    assign w_wdata.id       = w_id_inc;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    unique case (i_cmd.payload.command)
                        CMD_ADD:        n_state = S_ADD_SCAN;
                        CMD_CANCEL:     n_state = S_CANCEL_SCAN;
                        CMD_CANCEL_ALL: n_state = S_CALL_SCAN;
                        CMD_TICK:       n_state = S_TICK_SCAN;
                        default:        n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_SCAN: begin
                if (!w_scan_more || w_add_free) begin
                    n_state = S_RESP;
                end
            end
            S_CANCEL_SCAN: begin
                if (w_hit || w_pass_end) begin
                    n_state = S_RESP;
                end
            end
            S_CALL_SCAN: begin
                if (!w_scan_more) begin
                    n_state = S_RESP;
                end
            end
            S_TICK_SCAN: begin
                if (w_pass_end) begin
                    n_state = S_TICK_NEXT;
                end
            end
            S_TICK_NEXT: begin
                if (r_best_found) begin
                    if (!r_pend_vld || w_out_free) begin
                        n_state = S_TICK_SCAN;
                    end
                end else if (r_pend_vld) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_cmd_ready = 1'b0;
        w_mem_rd    = 1'b0;
        w_mem_we    = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            S_IDLE:        w_cmd_ready = 1'b1;
            S_ADD_SCAN:    w_mem_we    = w_add_free;
            S_CANCEL_SCAN: w_mem_rd    = w_scan_more;
            S_CALL_SCAN:   w_mem_rd    = 1'b0;
            S_TICK_SCAN:   w_mem_rd    = w_scan_more;
            S_TICK_NEXT:   w_load_out  = r_best_found && r_pend_vld && w_out_free;
            S_RESP:        w_load_out  = w_out_free;
            default:       w_cmd_ready = 1'b0;
        endcase
    end

    assign i_cmd.ready   = w_cmd_ready && i_rst_n;
    assign o_res.valid   = r_out_vld;
    assign o_res.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= r_pend;
        end
        r_rd_slot <= w_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_canc       <= '0;
            r_time       <= '0;
            r_next_id    <= '0;
            r_out_vld    <= 1'b0;
            r_pend_vld   <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_best_found <= 1'b0;
            r_idx        <= '0;
            r_count      <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_mem_rd;
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd        <= i_cmd.payload;
                        r_idx        <= '0;
                        r_count      <= '0;
                        r_best_found <= 1'b0;
                        if (i_cmd.payload.command == CMD_TICK && r_time != '1) begin
                            r_time <= r_time + TIME_W'(1);
                        end
                    end
                end
                S_ADD_SCAN: begin
                    if (w_scan_more) begin
                        if (w_add_free) begin
                            r_valid[w_idx] <= 1'b1;
                            r_canc[w_idx]  <= 1'b0;
                            r_next_id      <= w_id_inc;
                            r_pend     <= make_res(KIND_ADD_ACK, w_id_inc, 1'b0, 1'b0,
                                                   '0, 1'b1);
                            r_pend_vld <= 1'b1;
                        end else begin
                            r_idx <= r_idx + CNT_W'(1);
                        end
                    end else begin
                        r_pend     <= make_res(KIND_ADD_ACK, '0, 1'b0, 1'b1, '0, 1'b1);
                        r_pend_vld <= 1'b1;
                    end
                end
                S_CANCEL_SCAN: begin
                    if (w_scan_more) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (w_hit) begin
                        r_canc[r_rd_slot] <= 1'b1;
                        r_pend     <= make_res(KIND_CANCEL_ACK, '0, 1'b0, 1'b1, '0, 1'b1);
                        r_pend_vld <= 1'b1;
                    end else if (w_pass_end) begin
                        r_pend     <= make_res(KIND_CANCEL_ACK, '0, 1'b0, 1'b0, '0, 1'b1);
                        r_pend_vld <= 1'b1;
                    end
                end
                S_CALL_SCAN: begin
                    if (w_scan_more) begin
                        if (r_valid[w_idx]) begin
                            r_canc[w_idx] <= 1'b1;
                            r_count       <= r_count + CNT_W'(1);
                        end
                        r_idx <= r_idx + CNT_W'(1);
                    end else begin
                        r_pend     <= make_res(KIND_CANCEL_ALL_ACK, '0, 1'b0, 1'b0,
                                               COUNT_W'(r_count), 1'b1);
                        r_pend_vld <= 1'b1;
                    end
                end
                S_TICK_SCAN: begin
                    if (w_scan_more) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (w_cand_exp && w_better) begin
                        r_best_found <= 1'b1;
                        r_best_slot  <= r_rd_slot;
                        r_best_canc  <= r_canc[r_rd_slot];
                        r_best_dl    <= w_rd.deadline;
                        r_best_id    <= w_rd.id;
                    end
                end
                S_TICK_NEXT: begin
                    if (r_best_found) begin
                        if (!r_pend_vld || w_out_free) begin
                            r_valid[r_best_slot] <= 1'b0;
                            r_canc[r_best_slot]  <= 1'b0;
                            r_pend       <= make_res(KIND_EXPIRY, r_best_id, r_best_canc,
                                                     1'b0, '0, 1'b0);
                            r_pend_vld   <= 1'b1;
                            r_idx        <= '0;
                            r_best_found <= 1'b0;
                        end
                    end else if (r_pend_vld) begin
                        r_pend.last <= 1'b1;
                    end
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_pend_vld <= 1'b0;
                    end
                end
                default: r_pend_vld <= 1'b0;
            endcase
        end
    end

    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.kind != KIND_EXPIRY |-> r_out.last)
        else $error("acknowledge beat without last");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_pend_vld)
        else $error("pending result left behind in idle");

    a_canc_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_canc & ~r_valid) == '0)
        else $error("cancel flag on an empty slot");

    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |=> r_next_id != '0)
        else $error("zero timer id issued");

endmodule

@@ src/tqc_slot_mem.sv @@
// Slot store: deadline and id per timer slot, one write and one read port,
// registered read data. Depends on tqc_pkg.
module tqc_slot_mem
    import tqc_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  t_slot                      i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output t_slot                      o_rdata
);

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for timer_queue_with_cancel: random command beats, random idling.
// Expected results come from a timer table model kept in a scoreboard class.
// Depends on tqc_pkg, tqc_stream_if and the block's RTL.
import tqc_pkg::*;

class timer_table_model;
    localparam int SLOTS = 16;

    logic [TIME_W-1:0] deadline [SLOTS];
    logic [ID_W-1:0]   id       [SLOTS];
    bit                used     [SLOTS];
    bit                canc     [SLOTS];
    logic [TIME_W-1:0] now;
    logic [ID_W-1:0]   last_id;
    t_res              pending [$];
    int                n_err;

    function new();
        foreach (used[i]) begin
            used[i] = 1'b0;
            canc[i] = 1'b0;
        end
        now     = '0;
        last_id = '0;
        n_err   = 0;
    endfunction

    function bit fires_first(int a, int b);
        if (canc[a] != canc[b]) return canc[a];
        if (!canc[a] && deadline[a] != deadline[b]) return deadline[a] < deadline[b];
        if (id[a] != id[b]) return id[a] < id[b];
        return a < b;
    endfunction

    function int next_expired();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (!used[i]) continue;
            if (!canc[i] && deadline[i] > now) continue;
            if (best < 0 || fires_first(i, best)) best = i;
        end
        return best;
    endfunction

    function void push(t_kind k, logic [ID_W-1:0] tid, bit c, bit st,
                       logic [COUNT_W-1:0] cnt, bit l);
        t_res r;
        r.kind          = k;
        r.timer_id      = tid;
        r.was_cancelled = c;
        r.status        = st;
        r.count         = cnt;
        r.last          = l;
        pending.push_back(r);
    endfunction

    function void note_command(t_cmd c);
        int              slot;
        int              held;
        int              n;
        bit              found;
        logic [TIME_W:0] sum;
        case (c.command)
            CMD_ADD: begin
                slot = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!used[i]) begin
                        slot = i;
                        break;
                    end
                end
                if (slot < 0) begin
                    push(KIND_ADD_ACK, '0, 1'b0, 1'b1, '0, 1'b1);
                end else begin
                    last_id = last_id + 1'b1;
                    if (last_id == '0) last_id = 1;
                    sum = {1'b0, now} + {{(TIME_W + 1 - DELAY_W){1'b0}}, c.delay};
                    deadline[slot] = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
                    id[slot]   = last_id;
                    used[slot] = 1'b1;
                    canc[slot] = 1'b0;
                    push(KIND_ADD_ACK, last_id, 1'b0, 1'b0, '0, 1'b1);
                end
            end
            CMD_CANCEL: begin
                found = 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (used[i] && !canc[i] && id[i] == c.target_id) begin
                        canc[i] = 1'b1;
                        found   = 1'b1;
                        break;
                    end
                end
                push(KIND_CANCEL_ACK, '0, 1'b0, found, '0, 1'b1);
            end
            CMD_CANCEL_ALL: begin
                held = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (used[i]) begin
                        canc[i] = 1'b1;
                        held++;
                    end
                end
                push(KIND_CANCEL_ALL_ACK, '0, 1'b0, 1'b0, held[COUNT_W-1:0], 1'b1);
            end
            CMD_TICK: begin
                if (now != {TIME_W{1'b1}}) now = now + 1'b1;
                n = 0;
                forever begin
                    slot = next_expired();
                    if (slot < 0) break;
                    push(KIND_EXPIRY, id[slot], canc[slot], 1'b0, '0, 1'b0);
                    used[slot] = 1'b0;
                    canc[slot] = 1'b0;
                    n++;
                end
                if (n > 0) pending[pending.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            n_err++;
        end
    endfunction

    function void check_result(t_res r);
        t_res e;
        if (pending.size() == 0) begin
            $error("result beat with nothing pending: kind %0d id %0h", r.kind, r.timer_id);
            n_err++;
            return;
        end
        e = pending.pop_front();
        cmp("kind", e.kind, r.kind);
        cmp("timer_id", e.timer_id, r.timer_id);
        cmp("was_cancelled", e.was_cancelled, r.was_cancelled);
        cmp("status", e.status, r.status);
        cmp("count", e.count, r.count);
        cmp("last", e.last, r.last);
    endfunction
endclass

module testbench;
    localparam int LIMIT   = 1000000;
    localparam int N_TOTAL = 430;

    logic clk;
    logic rst_n;
    int   n_cycles;
    int   n_sent;
    int   adds_sent;
    int   tx_calm;
    int   rx_calm;

    timer_table_model sb;

    tqc_stream_if #(.T(t_cmd)) cmd_if ();
    tqc_stream_if #(.T(t_res)) res_if ();

    timer_queue_with_cancel #(
        .TIMER_SLOTS(16)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cmd  (cmd_if.sink),
        .o_res  (res_if.source)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        n_cycles++;
        if (n_cycles >= LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && cmd_if.valid && cmd_if.ready) sb.note_command(cmd_if.payload);
        if (rst_n && res_if.valid && res_if.ready) sb.check_result(res_if.payload);
    end

    // zero gaps for a stretch now and then
    function automatic int pause_len(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [ID_W-1:0] recent_id();
        int lo;
        lo = (adds_sent > 20) ? adds_sent - 20 : 0;
        return $urandom_range(lo, adds_sent + 1);
    endfunction

    task automatic send_cmd(input t_cmd_code op, input logic [DELAY_W-1:0] dly,
                            input logic [ID_W-1:0] tgt);
        t_cmd c;
        int   gap;
        c.command   = op;
        c.delay     = dly;
        c.target_id = tgt;
        gap = pause_len(tx_calm);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.payload <= c;
        cmd_if.valid   <= 1'b1;
        do @(posedge clk); while (!cmd_if.ready);
        if (op == CMD_ADD) adds_sent++;
        n_sent++;
    endtask

    // result side; one long hold-off lets the block back up into the command side
    initial begin
        int stall;
        int n_rx;
        n_rx = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = (n_rx == 60) ? 500 : pause_len(rx_calm);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
            n_rx++;
        end
    end

    initial begin
        int                 pick;
        int                 len;
        int                 r;
        t_cmd_code          op;
        logic [DELAY_W-1:0] dly;
        logic [ID_W-1:0]    tgt;

        clk            = 1'b0;
        rst_n          = 1'b0;
        n_cycles       = 0;
        n_sent         = 0;
        adds_sent      = 0;
        tx_calm        = 0;
        rx_calm        = 0;
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        res_if.ready   = 1'b0;
        sb             = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: delay extremes, misses, cancelled-first order, ties, empty table
        send_cmd(CMD_ADD, 32'd0, $urandom);
        send_cmd(CMD_ADD, 32'd1, $urandom);
        send_cmd(CMD_ADD, 32'hFFFF_FFFF, $urandom);
        send_cmd(CMD_ADD, 32'h8000_0000, $urandom);
        send_cmd(CMD_ADD, 32'd2, $urandom);
        send_cmd(CMD_ADD, 32'd1, $urandom);
        send_cmd(CMD_CANCEL, $urandom, 32'd0);
        send_cmd(CMD_CANCEL, $urandom, 32'hFFFF_FFFF);
        send_cmd(CMD_CANCEL, $urandom, 32'd3);
        send_cmd(CMD_CANCEL, $urandom, 32'd3);
        send_cmd(CMD_TICK, $urandom, $urandom);
        send_cmd(CMD_TICK, $urandom, $urandom);
        send_cmd(CMD_TICK, $urandom, $urandom);
        send_cmd(CMD_CANCEL, $urandom, 32'd4);
        send_cmd(CMD_CANCEL_ALL, $urandom, $urandom);
        send_cmd(CMD_TICK, $urandom, $urandom);
        send_cmd(CMD_CANCEL_ALL, $urandom, $urandom);
        send_cmd(CMD_ADD, 32'd0, $urandom);
        send_cmd(CMD_ADD, 32'd0, $urandom);
        send_cmd(CMD_CANCEL_ALL, $urandom, $urandom);
        send_cmd(CMD_TICK, $urandom, $urandom);

        while (n_sent < N_TOTAL) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                len = $urandom_range(15, 25);
                repeat (len) begin
                    r   = $urandom_range(0, 99);
                    dly = $urandom;
                    tgt = $urandom;
                    if (r < 35) begin
                        op = CMD_ADD;
                        r  = $urandom_range(0, 99);
                        if (r < 80) dly = $urandom_range(0, 6);
                        else if (r < 90) dly = $urandom_range(7, 100);
                    end else if (r < 55) begin
                        op = CMD_CANCEL;
                        if ($urandom_range(0, 4) != 0) tgt = recent_id();
                    end else if (r < 60) begin
                        op = CMD_CANCEL_ALL;
                    end else begin
                        op = CMD_TICK;
                    end
                    send_cmd(op, dly, tgt);
                end
            end else if (pick < 9) begin
                // fill past capacity, then flush
                repeat (18) begin
                    dly = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(20, 5000);
                    send_cmd(CMD_ADD, dly, $urandom);
                end
                send_cmd(CMD_CANCEL, $urandom, recent_id());
                send_cmd(CMD_CANCEL, $urandom, recent_id());
                send_cmd(CMD_CANCEL_ALL, $urandom, $urandom);
                send_cmd(CMD_TICK, $urandom, $urandom);
                send_cmd(CMD_TICK, $urandom, $urandom);
            end else begin
                repeat (10) send_cmd(t_cmd_code'($urandom_range(0, 3)), $urandom, $urandom);
            end
        end
        cmd_if.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.n_err == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
src/tqc_pkg.sv
src/tqc_stream_if.sv
src/tqc_slot_mem.sv
src/timer_queue_with_cancel.sv
sim/testbench.sv
